>>> hdl/wrm_pkg.sv
// wrm_pkg: shared types and constants for the window residency manager
// no dependencies
package wrm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UNLOAD,
        ST_LOAD,
        ST_EMIT,
        ST_DONE
    } wrm_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan_slot;
        logic scan_need;
    } wrm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pair_done;
        logic slot_done;
        logic need_done;
        logic hit;
        logic cand_ok;
    } wrm_stat_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_DEPTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

endpackage

>>> hdl/wrm_datapath.sv
// wrm_datapath: slot table, needed-set generator and compare logic
// depends on wrm_pkg
module wrm_datapath import wrm_pkg::*; #(
    parameter int LOAD_RADIUS = 1,
    parameter int MAX_HEIGHT  = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  wrm_cmd_t         cmd,
    output wrm_stat_t        stat,
    input  logic signed [15:0] viewer_x,
    input  logic signed [15:0] viewer_z,
    input  logic [14:0]      map_width,
    input  logic [14:0]      map_depth,
    input  logic [1:0]       map_height,
    output logic [31:0]      emit_code
);
    localparam int SPAN  = 2 * LOAD_RADIUS + 1;
    localparam int SLOTS = SPAN * SPAN * MAX_HEIGHT;
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int DW    = $clog2(SPAN + 1);

    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] found_reg;   // needed candidates already resident
    logic [31:0]      coords_reg [SLOTS];
    logic [31:0]      slot_code_reg;
    logic signed [16:0] vx_reg, vz_reg;

    // slot pointer and needed-set pointer (dz, dx, y)
    logic [SW-1:0] si_reg;
    logic [SW-1:0] ni_reg;
    logic [DW-1:0] dz_reg, dx_reg;
    logic [1:0]    y_reg;
    // inner compare pointer, also kept as (dz, dx, y)
    logic [SW-1:0] cj_reg;
    logic [DW-1:0] jdz_reg, jdx_reg;
    logic [1:0]    jy_reg;
    logic          hit_reg;
    logic [31:0]   emit_reg;

    logic [1:0] h;
    assign h = (map_height > 2'(MAX_HEIGHT)) ? 2'(MAX_HEIGHT) : map_height;

    // candidate for current needed pointer
    logic signed [17:0] cx, cz;
    logic        cand_ok;
    logic [31:0] cand;
    assign cx = 18'(vx_reg) + 18'(signed'({1'b0, dx_reg})) - 18'(LOAD_RADIUS);
    assign cz = 18'(vz_reg) + 18'(signed'({1'b0, dz_reg})) - 18'(LOAD_RADIUS);
    assign cand_ok = (cx >= 0) && (cz >= 0) && (cx < signed'({3'b0, map_width}))
        && (cz < signed'({3'b0, map_depth})) && (y_reg < h);
    assign cand = {cz[14:0], y_reg, cx[14:0]};

    // candidate at compare pointer cj for the unload walk
    logic signed [17:0] jcx, jcz;
    logic        jok;
    logic [31:0] jcand;
    assign jcx = 18'(vx_reg) + 18'(signed'({1'b0, jdx_reg})) - 18'(LOAD_RADIUS);
    assign jcz = 18'(vz_reg) + 18'(signed'({1'b0, jdz_reg})) - 18'(LOAD_RADIUS);
    assign jok = (jcx >= 0) && (jcz >= 0) && (jcx < signed'({3'b0, map_width}))
        && (jcz < signed'({3'b0, map_depth})) && (jy_reg < h);
    assign jcand = {jcz[14:0], jy_reg, jcx[14:0]};

    logic [SW-1:0] slot_ix;
    assign slot_ix = si_reg;

    // lowest free slot
    logic [SW-1:0] free_ix;
    always_comb
    begin
        free_ix = SW'(SLOTS);
        for (int k = SLOTS - 1; k >= 0; k--)
            if (!valid_reg[k])
                free_ix = SW'(k);
    end

    // the slot walk uses one compare per cycle against needed entry cj, while scan_slot is issued
    logic pair_match;
    assign pair_match = valid_reg[slot_ix[SW-1:0]] && jok && !found_reg[cj_reg]
        && (slot_code_reg == jcand);

    assign stat.pair_done = (cj_reg == SW'(SLOTS - 1)) || pair_match
        || !valid_reg[slot_ix];
    assign stat.slot_done = (si_reg == SW'(SLOTS - 1));
    assign stat.need_done = (ni_reg == SW'(SLOTS - 1));
    assign stat.hit       = hit_reg || pair_match || !valid_reg[slot_ix];
    assign stat.cand_ok   = cand_ok && !found_reg[ni_reg];
    assign emit_code      = emit_reg;

    // slot table port: coordinates of the slot being walked are fetched ahead
    logic          slot_wr, slot_rd;
    logic [SW-1:0] rd_ix;
    assign slot_wr = cmd.scan_need && stat.cand_ok && (free_ix != SW'(SLOTS));
    assign slot_rd = cmd.start || (cmd.scan_slot && stat.pair_done && !stat.slot_done);
    assign rd_ix   = cmd.start ? '0 : si_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (slot_wr)
            coords_reg[free_ix] <= cand;
        if (slot_rd)
            slot_code_reg <= coords_reg[rd_ix];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
            found_reg <= '0;
            vx_reg    <= '0;
            vz_reg    <= '0;
            emit_reg  <= '0;
            si_reg    <= '0;
            ni_reg    <= '0;
            cj_reg    <= '0;
            jdz_reg   <= '0;
            jdx_reg   <= '0;
            jy_reg    <= '0;
            hit_reg   <= 1'b0;
            dz_reg    <= '0;
            dx_reg    <= '0;
            y_reg     <= '0;
        end else begin
            if (cmd.start) begin
                vx_reg    <= 17'(viewer_x);
                vz_reg    <= 17'(viewer_z);
                found_reg <= '0;
                si_reg    <= '0;
                ni_reg    <= '0;
                cj_reg    <= '0;
                jdz_reg   <= '0;
                jdx_reg   <= '0;
                jy_reg    <= '0;
                hit_reg   <= 1'b0;
                dz_reg    <= '0;
                dx_reg    <= '0;
                y_reg     <= '0;
            end
            if (cmd.scan_slot) begin
                if (pair_match) begin
                    found_reg[cj_reg] <= 1'b1;
                    hit_reg <= 1'b1;
                end
                if (stat.pair_done) begin
                    cj_reg  <= '0;
                    jdz_reg <= '0;
                    jdx_reg <= '0;
                    jy_reg  <= '0;
                    hit_reg <= 1'b0;
                    if (!stat.hit) begin
                        valid_reg[slot_ix] <= 1'b0;
                        emit_reg <= slot_code_reg;
                    end
                    if (!stat.slot_done)
                        si_reg <= si_reg + 1'b1;
                end else begin
                    cj_reg <= cj_reg + 1'b1;
                    if (jy_reg == 2'(MAX_HEIGHT - 1)) begin
                        jy_reg <= '0;
                        if (jdx_reg == DW'(SPAN - 1)) begin
                            jdx_reg <= '0;
                            jdz_reg <= jdz_reg + 1'b1;
                        end else begin
                            jdx_reg <= jdx_reg + 1'b1;
                        end
                    end else begin
                        jy_reg <= jy_reg + 1'b1;
                    end
                end
            end
            if (cmd.scan_need) begin
                if (stat.cand_ok) begin
                    emit_reg <= cand;
                    if (free_ix != SW'(SLOTS))
                        valid_reg[free_ix] <= 1'b1;
                end
                ni_reg <= ni_reg + 1'b1;
                if (y_reg == 2'(MAX_HEIGHT - 1)) begin
                    y_reg <= '0;
                    if (dx_reg == DW'(SPAN - 1)) begin
                        dx_reg <= '0;
                        dz_reg <= dz_reg + 1'b1;
                    end else begin
                        dx_reg <= dx_reg + 1'b1;
                    end
                end else begin
                    y_reg <= y_reg + 1'b1;
                end
            end
        end
    end
endmodule

>>> hdl/wrm_ctrl.sv
// wrm_ctrl: sequencer for the unload and load walks, output register
// depends on wrm_pkg
module wrm_ctrl import wrm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output wrm_cmd_t   cmd,
    input  wrm_stat_t  stat,
    input  logic [31:0] emit_code,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_load,
    output logic [14:0] chunk_x,
    output logic [1:0] chunk_y,
    output logic [14:0] chunk_z,
    output logic       last
);
    wrm_state_t state_reg, state_next;

    // one result is held back so last can be set on the final one
    logic pend_reg, pend_next;
    logic pend_load_reg, pend_load_next;
    logic [31:0] pend_code_reg;
    logic ov_reg, ov_next;
    logic ol_reg, ol_next, olast_reg, olast_next;
    logic [31:0] ocode_reg;
    logic gen_reg, gen_next;      // fresh result in emit_code
    logic gen_load_reg, gen_load_next;

    logic out_free;
    assign out_free = !ov_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            pend_load_reg <= 1'b0;
            ov_reg        <= 1'b0;
            ol_reg        <= 1'b0;
            olast_reg     <= 1'b0;
            gen_reg       <= 1'b0;
            gen_load_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            pend_load_reg <= pend_load_next;
            ov_reg        <= ov_next;
            ol_reg        <= ol_next;
            olast_reg     <= olast_next;
            gen_reg       <= gen_next;
            gen_load_reg  <= gen_load_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen_reg && (!pend_reg || out_free))
            pend_code_reg <= emit_code;
        if (out_free && pend_reg && (gen_reg || state_reg == ST_DONE))
            ocode_reg <= pend_code_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        pend_next      = pend_reg;
        pend_load_next = pend_load_reg;
        ov_next        = ov_reg && out_stall;
        ol_next        = ol_reg;
        olast_next     = olast_reg;
        gen_next       = 1'b0;
        gen_load_next  = gen_load_reg;

        // move fresh result into the pending slot, shifting pending out
        if (gen_reg) begin
            if (pend_reg) begin
                // out_free guaranteed by the stall of the walks below
                ov_next    = 1'b1;
                ol_next    = pend_load_reg;
                olast_next = 1'b0;
            end
            pend_next      = 1'b1;
            pend_load_next = gen_load_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_UNLOAD;
                end
            end
            ST_UNLOAD:
            begin
                if (out_free && !gen_reg) begin
                    cmd.scan_slot = 1'b1;
                    if (stat.pair_done && !stat.hit) begin
                        gen_next      = 1'b1;
                        gen_load_next = 1'b0;
                    end
                    if (stat.pair_done && stat.slot_done)
                        state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free && !gen_reg) begin
                    cmd.scan_need = 1'b1;
                    if (stat.cand_ok) begin
                        gen_next      = 1'b1;
                        gen_load_next = 1'b1;
                    end
                    if (stat.need_done)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!gen_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!pend_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    ov_next    = 1'b1;
                    ol_next    = pend_load_reg;
                    olast_next = 1'b1;
                    pend_next  = 1'b0;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = ov_reg;
    assign is_load   = ol_reg;
    assign last      = olast_reg;
    assign chunk_x   = ocode_reg[14:0];
    assign chunk_y   = ocode_reg[16:15];
    assign chunk_z   = ocode_reg[31:17];
endmodule

>>> hdl/window_residency_manager.sv
// window_residency_manager: top level, config registers, controller and datapath
// depends on wrm_pkg, wrm_ctrl, wrm_datapath
//
//  channel  | handshake          | payload
//  in       | in_valid/in_stall  | viewer_x, viewer_z
//  out      | out_valid/out_stall| is_load, chunk_x, chunk_y, chunk_z, last
//  cfg      | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// one item is processed between input transfers; the input stays stalled until it is done.
// The time is set by the unload walk comparing each slot against each window entry in
// turn, then by the load walk visiting each window entry and by each result; while a
// waiting result is stalled at the output, the walks wait too
// async active-low reset empties the slot table and restores map registers to 1
module window_residency_manager import wrm_pkg::*; #(
    parameter int LOAD_RADIUS = 1,
    parameter int MAX_HEIGHT  = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic signed [15:0] viewer_x,
    input  logic signed [15:0] viewer_z,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              is_load,
    output logic [14:0]       chunk_x,
    output logic [1:0]        chunk_y,
    output logic [14:0]       chunk_z,
    output logic              last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [14:0]       cfg_data
);
    logic [14:0] width_reg, depth_reg;
    logic [1:0]  height_reg;
    wrm_cmd_t    cmd;
    wrm_stat_t   stat;
    logic [31:0] emit_code;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= 15'd1;
            depth_reg  <= 15'd1;
            height_reg <= 2'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_DEPTH:  depth_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    wrm_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .cmd, .stat, .emit_code,
        .out_valid, .out_stall, .is_load, .chunk_x, .chunk_y, .chunk_z, .last
    );

    wrm_datapath #(.LOAD_RADIUS(LOAD_RADIUS), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .clk, .rst_n, .cmd, .stat, .viewer_x, .viewer_z,
        .map_width(width_reg), .map_depth(depth_reg), .map_height(height_reg),
        .emit_code
    );
endmodule

>>> hdl/wrm_checker.sv
// wrm_checker: port-level assertions for the window residency manager
// depends on window_residency_manager
module wrm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_load,
    input logic       last
);
    // while input is open only the final result of the previous item may wait
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid || last) else $error("input open during output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(last) && $stable(is_load))
        else $error("stalled result changed");

    // unloads come before loads within one item
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && is_load && !last |=>
        !(out_valid && !is_load)) else $error("unload after load");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall) else $error("accepted twice");
endmodule

bind window_residency_manager wrm_checker u_chk (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .is_load, .last
);

>>> bench/tb_window_residency_manager.sv
// tb_window_residency_manager: self-checking bench for the window residency manager
// depends on wrm_pkg and window_residency_manager; predicts each load/unload transfer
// and checks every output field in order against the prediction
module tb_window_residency_manager import wrm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RADIUS    = 1;
    localparam int HEIGHT    = 3;
    localparam int SPAN      = 2 * RADIUS + 1;
    localparam int NSLOT     = SPAN * SPAN * HEIGHT;
    localparam int SETTLE    = 1200;
    localparam int RAND_SETS = 6;
    localparam int RAND_ITEMS = 24;

    typedef struct packed {
        logic        is_load;
        logic [14:0] x;
        logic [1:0]  y;
        logic [14:0] z;
        logic        last;
    } chunk_req_t;

    typedef struct {
        bit cfg_row;
        int w, d, h;
        int vx, vz;
        bit typed;
        int tn;
        int tload, tx, ty, tz;
    } step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic signed [15:0] viewer_x = '0;
    logic signed [15:0] viewer_z = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        is_load, last;
    logic [14:0] chunk_x, chunk_z;
    logic [1:0]  chunk_y;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [14:0] cfg_data = '0;

    window_residency_manager #(.LOAD_RADIUS(RADIUS), .MAX_HEIGHT(HEIGHT)) u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the map registers and slot table
    int          map_w = 1, map_d = 1, map_h = 1;
    bit          resident[NSLOT];
    logic [31:0] resident_at[NSLOT];
    chunk_req_t  batch[$];
    chunk_req_t  pending_reqs[$];
    int          fails = 0;

    function automatic logic [31:0] pack_chunk(int cx, int cy, int cz);
        return {cz[14:0], cy[1:0], cx[14:0]};
    endfunction

    function automatic chunk_req_t make_req(bit ld, logic [31:0] code);
        chunk_req_t r;
        r.is_load = ld;
        r.x = code[14:0];
        r.y = code[16:15];
        r.z = code[31:17];
        r.last = 1'b0;
        return r;
    endfunction

    // fills batch with the requests one viewer move causes, updates the slot table
    function automatic void window_update(logic signed [15:0] vx, logic signed [15:0] vz);
        logic [31:0] need[NSLOT];
        bit          live[NSLOT];
        int          n, h, cx, cz;
        bit          found;
        n = 0;
        h = (map_h > HEIGHT) ? HEIGHT : map_h;
        batch.delete();
        for (int dz = -RADIUS; dz <= RADIUS; dz++)
        begin
            for (int dx = -RADIUS; dx <= RADIUS; dx++)
            begin
                cz = int'(vz) + dz;
                cx = int'(vx) + dx;
                if (cz < 0 || cz >= map_d || cx < 0 || cx >= map_w)
                    continue;
                for (int y = 0; y < h; y++)
                begin
                    need[n] = pack_chunk(cx, y, cz);
                    live[n] = 1'b1;
                    n++;
                end
            end
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            found = 1'b0;
            if (!resident[i])
                continue;
            for (int j = 0; j < n; j++)
            begin
                if (live[j] && need[j] == resident_at[i])
                begin
                    live[j] = 1'b0;
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                batch.insert(batch.size(), make_req(1'b0, resident_at[i]));
                resident[i] = 1'b0;
            end
        end
        for (int j = 0; j < n; j++)
        begin
            if (!live[j])
                continue;
            batch.insert(batch.size(), make_req(1'b1, need[j]));
            for (int i = 0; i < NSLOT; i++)
            begin
                if (!resident[i])
                begin
                    resident[i] = 1'b1;
                    resident_at[i] = need[j];
                    break;
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 5);
        return $urandom_range(20, 300);
    endfunction

    // output-side stall pattern, with calm stretches
    int stall_left = 0;
    bit stall_on = 1'b0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_on = ($urandom_range(0, 3) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
            stall_left = stall_on ? pick_gap() + 1 : $urandom_range(1, 200);
        end
        else
            stall_left--;
        out_stall <= stall_on;
    end

    // checker: each output transfer against the oldest prediction
    always @(posedge clk)
    begin
        chunk_req_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reqs.size() == 0)
                report_mismatch("output transfer with nothing expected");
            else
            begin
                want = pending_reqs.pop_front();
                if (is_load !== want.is_load)
                    report_mismatch($sformatf("is_load %b want %b", is_load, want.is_load));
                if (chunk_x !== want.x)
                    report_mismatch($sformatf("chunk_x %0d want %0d", chunk_x, want.x));
                if (chunk_y !== want.y)
                    report_mismatch($sformatf("chunk_y %0d want %0d", chunk_y, want.y));
                if (chunk_z !== want.z)
                    report_mismatch($sformatf("chunk_z %0d want %0d", chunk_z, want.z));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b want %b", last, want.last));
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_map(int w, int d, int h);
        logic [1:0] idx[3];
        int         val[3];
        idx = '{CFG_WIDTH, CFG_DEPTH, CFG_HEIGHT};
        val = '{w, d, h};
        for (int k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k][14:0];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        map_w = w & 16'h7fff;
        map_d = d & 16'h7fff;
        map_h = h & 3;
    endtask

    // one viewer transfer; typed rows queue the hand-written answer instead
    task automatic send_view(int vx, int vz, bit typed = 0, int tn = 0,
                             chunk_req_t texp = '0);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        viewer_x <= vx[15:0];
        viewer_z <= vz[15:0];
        do @(posedge clk); while (in_stall);
        window_update(vx[15:0], vz[15:0]);
        if (typed)
        begin
            if (batch.size() != tn)
                report_mismatch($sformatf("hand result count %0d vs %0d", tn, batch.size()));
            if (tn == 1)
                pending_reqs.insert(pending_reqs.size(), texp);
        end
        else
            foreach (batch[k])
                pending_reqs.insert(pending_reqs.size(), batch[k]);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 6);
        if (r == 7)
            return 32767;
        if (r == 8)
            return $urandom_range(0, 1);
        return $urandom_range(0, 32767);
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    step_t steps[] = '{
        '{0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 5, 5, 1, 1, 0, 0, 0, 0},
        '{0, 0, 0, 0, -32768, -32768, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 32767, 32767, 1, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 1, 1, 1, 1, 1, 0, 0, 0},
        '{0, 0, 0, 0, -1, -1, 1, 0, 0, 0, 0, 0},
        '{1, 32767, 32767, 3, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 32767, 32767, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 32766, 32766, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 16383, 16383, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 16384, 16383, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 16384, 16384, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, -2, -2, 0, 0, 0, 0, 0, 0},
        '{1, 2, 3, 2, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 1, 2, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 2, 3, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
        // height zero: everything resident goes away
        '{1, 4, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0, 0},
        // zero width: no column is on the map
        '{1, 0, 5, 3, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0},
        '{1, 3, 3, 3, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, 0, -32768, 32767, 0, 0, 0, 0, 0, 0}
    };

    initial
    begin
        chunk_req_t texp;
        int w, d, cur_x, cur_z, r;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (steps[i])
        begin
            if (steps[i].cfg_row)
            begin
                idle_input();
                drain();
                write_map(steps[i].w, steps[i].d, steps[i].h);
            end
            else
            begin
                texp = make_req(steps[i].tload[0],
                                pack_chunk(steps[i].tx, steps[i].ty, steps[i].tz));
                texp.last = 1'b1;
                send_view(steps[i].vx, steps[i].vz, steps[i].typed, steps[i].tn, texp);
            end
        end

        for (int s = 0; s < RAND_SETS; s++)
        begin
            idle_input();
            drain();
            w = pick_size();
            d = pick_size();
            write_map(w, d, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 3);
            cur_x = (w > 8 && $urandom_range(0, 1)) ? w - 1 : $urandom_range(0, (w > 8) ? w : 3);
            cur_z = (d > 8 && $urandom_range(0, 1)) ? d - 1 : $urandom_range(0, (d > 8) ? d : 3);
            for (int k = 0; k < RAND_ITEMS; k++)
            begin
                r = $urandom_range(0, 9);
                if (r < 8)
                begin
                    // small moves keep most of the window resident
                    cur_x = clamp16(cur_x + $urandom_range(0, 2) - 1);
                    cur_z = clamp16(cur_z + $urandom_range(0, 2) - 1);
                    if (cur_x < -2 || cur_x > w + 1)
                        cur_x = $urandom_range(0, 1) ? w - 1 : 0;
                    if (cur_z < -2 || cur_z > d + 1)
                        cur_z = $urandom_range(0, 1) ? d - 1 : 0;
                    send_view(cur_x, cur_z);
                end
                else
                    send_view(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
                if (k == RAND_ITEMS / 2)
                begin
                    idle_input();
                    while (pending_reqs.size() != 0)
                        @(posedge clk);
                end
            end
        end

        idle_input();
        drain();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

endmodule
